// ===== hw/rtl/pgp_signature_packet_parser_defines.svh =====
// Assertion macros for the parser's checker.
`ifndef PGP_SIGNATURE_PACKET_PARSER_DEFINES_SVH
`define PGP_SIGNATURE_PACKET_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PGPSIG_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pgpsig: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PGPSIG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pgpsig: next-cycle check failed");

`endif

// ===== hw/rtl/pgpsig_pkg.sv =====
package pgpsig_pkg;

   localparam int MAX_FIELD_BITS = 16;

   typedef enum logic [4:0] {
      PH_VER, PH_FIVE, PH_CLASS, PH_TIME, PH_KEY, PH_ALG, PH_HASH,
      PH_ALEN_HI, PH_ALEN_LO, PH_SLEN1, PH_SLEN2, PH_STYPE, PH_SBODY,
      PH_CK1, PH_CK2, PH_MPI_HI, PH_MPI_LO, PH_MPI_BODY, PH_TRAIL, PH_ERR
   } phase_type;

   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_BAD_VERSION   = 3'd1;
   localparam logic [2:0] ST_BAD_MARKER    = 3'd2;
   localparam logic [2:0] ST_TRUNCATED     = 3'd3;
   localparam logic [2:0] ST_AREA_MISMATCH = 3'd4;

   localparam logic [7:0]  V3_MARKER      = 8'd5;
   localparam logic [7:0]  VERSION_2      = 8'd2;
   localparam logic [7:0]  VERSION_3      = 8'd3;
   localparam logic [7:0]  VERSION_4      = 8'd4;
   localparam logic [7:0]  ALG_DSA        = 8'd17;
   localparam logic [7:0]  ALG_RSA_LAST   = 8'd3;
   localparam logic [7:0]  LEN2_MIN       = 8'd192;
   localparam logic [6:0]  SUB_TIME       = 7'd2;
   localparam logic [6:0]  SUB_ISSUER     = 7'd16;
   localparam logic [1:0]  MPI_ONE        = 2'd1;
   localparam logic [1:0]  MPI_TWO        = 2'd2;
   localparam logic [1:0]  MPI_ANY        = 2'd3;
   localparam logic [63:0] PLACEHOLDER_ID = 64'h3F3F_3F3F_3F3F_3F3F;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       last_byte;
   } pgpsig_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  signature_class;
      logic [31:0] creation_time;
      logic [63:0] signer_key_id;
      logic        key_id_found;
   } pgpsig_rsp_type;

   typedef struct packed {
      phase_type                  phase;
      logic [2:0]                 version_seen;
      logic [MAX_FIELD_BITS-1:0]  field_remaining;
      logic signed [16:0]         area_remaining;
      logic [14:0]                sub_remaining;
      logic [6:0]                 sub_kind;
      logic                       area_index;
      logic [1:0]                 mpi_left;
      logic [31:0]                gather;
      logic [7:0]                 class_held;
      logic [31:0]                time_held;
      logic [63:0]                key_held;
      logic                       key_seen;
      logic [2:0]                 error_held;
   } pgpsig_state_type;

   localparam pgpsig_state_type STATE_RESET = '{
      phase:           PH_VER,
      version_seen:    3'd0,
      field_remaining: '0,
      area_remaining:  17'sd0,
      sub_remaining:   15'd0,
      sub_kind:        7'd0,
      area_index:      1'b0,
      mpi_left:        2'd0,
      gather:          32'd0,
      class_held:      8'd0,
      time_held:       32'd0,
      key_held:        64'd0,
      key_seen:        1'b0,
      error_held:      3'd0
   };

endpackage

// ===== hw/rtl/pgpsig_core.sv =====
module pgpsig_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  pgpsig_pkg::pgpsig_req_type item,
   output pgpsig_pkg::pgpsig_rsp_type result
);
   import pgpsig_pkg::*;

   pgpsig_state_type state_ff;
   pgpsig_state_type state_in;

   // End of one subpacket area: the hashed area is followed by the unhashed one.
   function automatic pgpsig_state_type area_done(input pgpsig_state_type s);
      pgpsig_state_type r;
      r = s;
      if (!s.area_index) begin
         r.area_index = 1'b1;
         r.phase = PH_ALEN_HI;
      end else begin
         r.phase = PH_CK1;
      end
      return r;
   endfunction

   function automatic pgpsig_state_type sub_done(input pgpsig_state_type s);
      pgpsig_state_type r;
      r = s;
      if (!s.area_remaining[16] && (s.area_remaining != 17'sd0)) begin
         r.phase = PH_SLEN1;
      end else begin
         r = area_done(s);
      end
      return r;
   endfunction

   function automatic pgpsig_state_type mpi_done(input pgpsig_state_type s);
      pgpsig_state_type r;
      r = s;
      if (s.mpi_left == MPI_ANY) begin
         r.phase = PH_MPI_HI;
      end else begin
         r.mpi_left = s.mpi_left - 2'd1;
         r.phase = (r.mpi_left == 2'd0) ? PH_TRAIL : PH_MPI_HI;
      end
      return r;
   endfunction

   function automatic pgpsig_state_type fail(input pgpsig_state_type s,
                                             input logic [2:0] code);
      pgpsig_state_type r;
      r = s;
      r.error_held = code;
      r.phase = PH_ERR;
      return r;
   endfunction

   // A subpacket length has been read; it must be nonzero and fit in the area.
   function automatic pgpsig_state_type sub_start(input pgpsig_state_type s,
                                                  input logic [14:0] len);
      pgpsig_state_type   r;
      logic signed [17:0] area_sub;
      r = s;
      area_sub = $signed({s.area_remaining[16], s.area_remaining})
                 - $signed({3'b000, len});
      r.area_remaining = area_sub[16:0];
      r.sub_remaining = len;
      if (len == 15'd0 || area_sub[17]) begin
         r = fail(r, ST_AREA_MISMATCH);
      end else begin
         r.phase = PH_STYPE;
      end
      return r;
   endfunction

   logic [7:0]                b;
   logic signed [16:0]        area_dec;
   logic [14:0]               long_len;
   logic [14:0]               sub_rem_dec;
   logic [MAX_FIELD_BITS-1:0] field_dec;
   logic [MAX_FIELD_BITS-1:0] field_inc;
   logic [16:0]               mpi_round;
   logic [31:0]               gather_shift;

   assign b            = item.body_byte;
   assign area_dec     = state_ff.area_remaining - 17'sd1;
   assign long_len     = {1'b0, state_ff.gather[5:0], b} + 15'(LEN2_MIN);
   assign sub_rem_dec  = state_ff.sub_remaining - 15'd1;
   assign field_dec    = state_ff.field_remaining - 1'b1;
   assign field_inc    = state_ff.field_remaining + 1'b1;
   assign mpi_round    = {1'b0, state_ff.gather[7:0], b} + 17'd7;
   assign gather_shift = {state_ff.gather[23:0], b};

   always_comb begin
      state_in = state_ff;
      case (state_ff.phase)
         PH_VER: begin
            state_in.version_seen = b[2:0];
            if (b == VERSION_2 || b == VERSION_3) begin
               state_in.phase = PH_FIVE;
            end else if (b == VERSION_4) begin
               state_in.phase = PH_CLASS;
            end else begin
               state_in = fail(state_in, ST_BAD_VERSION);
            end
         end
         PH_FIVE: begin
            if (b == V3_MARKER) begin
               state_in.phase = PH_CLASS;
            end else begin
               state_in = fail(state_in, ST_BAD_MARKER);
            end
         end
         PH_CLASS: begin
            state_in.class_held = b;
            if (state_ff.version_seen == VERSION_4[2:0]) begin
               state_in.phase = PH_ALG;
            end else begin
               state_in.field_remaining = MAX_FIELD_BITS'(4);
               state_in.phase = PH_TIME;
            end
         end
         PH_TIME: begin
            state_in.time_held = {state_ff.time_held[23:0], b};
            state_in.field_remaining = field_dec;
            if (field_dec == '0) begin
               state_in.field_remaining = MAX_FIELD_BITS'(8);
               state_in.phase = PH_KEY;
            end
         end
         PH_KEY: begin
            state_in.key_held = {state_ff.key_held[55:0], b};
            state_in.field_remaining = field_dec;
            if (field_dec == '0) begin
               state_in.phase = PH_ALG;
            end
         end
         PH_ALG: begin
            if (b != 8'd0 && b <= ALG_RSA_LAST) begin
               state_in.mpi_left = MPI_ONE;
            end else if (b == ALG_DSA) begin
               state_in.mpi_left = MPI_TWO;
            end else begin
               state_in.mpi_left = MPI_ANY;
            end
            state_in.phase = PH_HASH;
         end
         PH_HASH: begin
            if (state_ff.version_seen == VERSION_4[2:0]) begin
               state_in.area_index = 1'b0;
               state_in.phase = PH_ALEN_HI;
            end else begin
               state_in.phase = PH_CK1;
            end
         end
         PH_ALEN_HI: begin
            state_in.gather = {24'd0, b};
            state_in.phase = PH_ALEN_LO;
         end
         PH_ALEN_LO: begin
            state_in.area_remaining = $signed({1'b0, state_ff.gather[7:0], b});
            if ({state_ff.gather[7:0], b} == 16'd0) begin
               state_in = area_done(state_in);
            end else begin
               state_in.phase = PH_SLEN1;
            end
         end
         PH_SLEN1: begin
            state_in.area_remaining = area_dec;
            if (b >= LEN2_MIN) begin
               state_in.gather = {26'd0, b[5:0]};
               state_in.phase = PH_SLEN2;
            end else begin
               state_in = sub_start(state_in, {7'd0, b});
            end
         end
         PH_SLEN2: begin
            state_in.area_remaining = area_dec;
            state_in = sub_start(state_in, long_len);
         end
         PH_STYPE: begin
            state_in.sub_kind = b[6:0];
            state_in.sub_remaining = sub_rem_dec;
            state_in.field_remaining = '0;
            state_in.gather = 32'd0;
            if (b[6:0] == SUB_ISSUER) begin
               // An empty issuer subpacket leaves the key id unknown.
               state_in.key_held = 64'd0;
               state_in.key_seen = (sub_rem_dec != 15'd0);
            end
            if (sub_rem_dec == 15'd0) begin
               state_in = sub_done(state_in);
            end else begin
               state_in.phase = PH_SBODY;
            end
         end
         PH_SBODY: begin
            if (state_ff.sub_kind == SUB_TIME && state_ff.field_remaining < 4) begin
               state_in.gather = gather_shift;
               state_in.field_remaining = field_inc;
               if (field_inc == MAX_FIELD_BITS'(4)) begin
                  state_in.time_held = gather_shift;
               end
            end else if (state_ff.sub_kind == SUB_ISSUER &&
                         state_ff.field_remaining < 8) begin
               state_in.key_held = {state_ff.key_held[55:0], b};
               state_in.field_remaining = field_inc;
            end
            state_in.sub_remaining = sub_rem_dec;
            if (sub_rem_dec == 15'd0) begin
               state_in = sub_done(state_in);
            end
         end
         PH_CK1: begin
            state_in.phase = PH_CK2;
         end
         PH_CK2: begin
            state_in.phase = PH_MPI_HI;
         end
         PH_MPI_HI: begin
            state_in.gather = {24'd0, b};
            state_in.phase = PH_MPI_LO;
         end
         PH_MPI_LO: begin
            // The MPI header counts bits; the body is that many bits rounded up to bytes.
            state_in.field_remaining = {2'b00, mpi_round[16:3]};
            if (mpi_round[16:3] == 14'd0) begin
               state_in = mpi_done(state_in);
            end else begin
               state_in.phase = PH_MPI_BODY;
            end
         end
         PH_MPI_BODY: begin
            state_in.field_remaining = field_dec;
            if (field_dec == '0) begin
               state_in = mpi_done(state_in);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result = '0;
      if (state_in.phase == PH_ERR) begin
         result.status = state_in.error_held;
      end else if (state_in.phase == PH_TRAIL ||
                   (state_in.phase == PH_MPI_HI && state_in.mpi_left == MPI_ANY)) begin
         result.status = ST_OK;
      end else begin
         result.status = ST_TRUNCATED;
      end
      if (result.status == ST_OK) begin
         result.signature_class = state_in.class_held;
         result.creation_time = state_in.time_held;
         if (state_in.version_seen == VERSION_4[2:0] && !state_in.key_seen) begin
            result.signer_key_id = PLACEHOLDER_ID;
            result.key_id_found = 1'b0;
         end else begin
            result.signer_key_id = state_in.key_held;
            result.key_id_found = 1'b1;
         end
      end
   end

   // The last byte of a packet returns the parser to its start for the next one.
   always_ff @(posedge clock) begin
      if (reset || (step_en && item.last_byte)) begin
         state_ff <= STATE_RESET;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/pgp_signature_packet_parser.sv =====
// Signature packet body parser for version 2, version 3 and version 4 packets.
// The req channel carries one body byte per item, with last_byte set on the
// final byte of the packet body. The rsp channel carries one item per packet:
// status, signature class, creation time, signer key id and a found flag.
// Items move on valid high and stall low at a rising clock edge.
// A byte is captured in an input register, then parsed into the packet state
// once the result register can take a result; the result of a last byte is
// registered into the result register and shown on rsp. One byte is taken
// every cycle when the result side does not stall.
// The result register is the only place a result waits: while it holds an
// item that the receiver stalls, bytes that are not yet parsed stay in the
// input register and req_stall rises once that register is full.
// Synchronous reset empties both registers and puts the parser back at the
// version byte; after a last byte the parser returns there on its own.
// Bytes after an error, and bytes after the required MPIs, are consumed
// without effect until the last byte.
module pgp_signature_packet_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  pgpsig_pkg::pgpsig_req_type  req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output pgpsig_pkg::pgpsig_rsp_type  rsp_data
);
   import pgpsig_pkg::*;

   logic           in_valid_ff;
   logic           in_valid_in;
   pgpsig_req_type in_data_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   pgpsig_rsp_type rsp_data_ff;
   pgpsig_rsp_type step_result;
   logic           out_free;
   logic           in_take;
   logic           step_en;
   logic           rsp_load;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_take   = req_valid && !req_stall;
   assign rsp_load  = step_en && in_data_ff.last_byte;

   pgpsig_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_data_ff),
      .result  (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_take) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_data_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/pgpsig_checker.sv =====
`include "pgp_signature_packet_parser_defines.svh"

module pgpsig_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input pgpsig_pkg::pgpsig_req_type  req_data,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input pgpsig_pkg::pgpsig_rsp_type  rsp_data
);
   import pgpsig_pkg::*;

   logic rsp_failed;
   logic rsp_good;
   logic rsp_held;
   logic failed_fields_zero;
   logic placeholder_ok;

   assign rsp_failed = rsp_valid && (rsp_data.status != ST_OK);
   assign rsp_good   = rsp_valid && (rsp_data.status == ST_OK);
   assign rsp_held   = rsp_valid && rsp_stall;
   assign failed_fields_zero = (rsp_data.signature_class == 8'd0) &&
                               (rsp_data.creation_time == 32'd0) &&
                               (rsp_data.signer_key_id == 64'd0) &&
                               !rsp_data.key_id_found;
   assign placeholder_ok = rsp_data.key_id_found ||
                           (rsp_data.signer_key_id == PLACEHOLDER_ID);

   // The input side only backs up when a finished result is held by the receiver.
   `PGPSIG_ASSERT_IMPL(a_stall_only_when_held, clock, reset, req_stall, rsp_held)
   `PGPSIG_ASSERT_IMPL(a_error_clears_fields, clock, reset, rsp_failed, failed_fields_zero)
   `PGPSIG_ASSERT_IMPL(a_missing_key_placeholder, clock, reset, rsp_good, placeholder_ok)
   `PGPSIG_ASSERT_NEXT(a_stalled_result_holds, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))

endmodule

bind pgp_signature_packet_parser pgpsig_checker u_pgpsig_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
